[sv/ibdz_pkg.sv]
package ibdz_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int COEF_FRAC  = 16;
	localparam int COEF_W     = COEF_FRAC + 2;
	localparam int DZ_W       = SAMPLE_W - 1;
	localparam int PROD_W     = SAMPLE_W + COEF_W;
	localparam int ACC_W      = PROD_W + 3;
	localparam int SHIFT_W    = ACC_W - COEF_FRAC;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = (DZ_W > COEF_W) ? DZ_W : COEF_W;
	localparam int MAC_STEPS  = 5;
	localparam int SEL_W      = 3;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_COEF_0     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COEF_1     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COEF_2     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEN_COEF_1     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEN_COEF_2     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DIVISOR_VALID  = 3'd6;

	localparam logic [SEL_W-1:0] SEL_X0 = 3'd0;
	localparam logic [SEL_W-1:0] SEL_X1 = 3'd1;
	localparam logic [SEL_W-1:0] SEL_X2 = 3'd2;
	localparam logic [SEL_W-1:0] SEL_Y1 = 3'd3;
	localparam logic [SEL_W-1:0] SEL_Y2 = 3'd4;

	localparam logic [0:0] REQ_FILTER = 1'b0;
	localparam logic [0:0] REQ_CLEAR  = 1'b1;

	typedef struct packed {
		logic                       req_type;
		logic signed [SAMPLE_W-1:0] sample_in;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filtered_out;
		logic                       held;
	} out_item_t;

	typedef struct packed {
		logic             hist_shift;
		logic             hist_clear;
		logic             acc_clr;
		logic             mul_en;
		logic [SEL_W-1:0] mul_sel;
		logic             round;
		logic             emit;
	} cmd_t;

endpackage

[sv/ibdz_ctrl.sv]
module ibdz_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_req_type,
	output logic              in_stall,
	input  logic              out_stall,
	output logic              out_valid,
	output ibdz_pkg::cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MAC   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_ROUND = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]                 state_q, state_d;
	logic [ibdz_pkg::SEL_W-1:0] cnt_q, cnt_d;
	logic                       out_valid_q, out_valid_d;
	logic                       in_acc;
	logic                       out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d        = state_q;
		cnt_d          = cnt_q;
		cmd            = '0;
		out_valid_d    = out_valid_q && out_stall;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (in_req_type == ibdz_pkg::REQ_CLEAR) begin
						cmd.hist_clear = 1'b1;
					end else begin
						cmd.hist_shift = 1'b1;
						cmd.acc_clr    = 1'b1;
						cnt_d          = '0;
						state_d        = ST_MAC;
					end
				end
			end
			ST_MAC: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = cnt_q;
				cnt_d       = cnt_q + 1'b1;
				if (cnt_q == ibdz_pkg::SEL_W'(ibdz_pkg::MAC_STEPS - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				// hold the result until the output register is free
				if (out_free) begin
					cmd.emit    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

[sv/ibdz_datapath.sv]
module ibdz_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ibdz_pkg::cmd_t                      cmd,
	input  logic signed [ibdz_pkg::SAMPLE_W-1:0] sample_in,
	input  logic                                cfg_we,
	input  logic [ibdz_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ibdz_pkg::CFG_DATA_W-1:0]     cfg_data,
	output ibdz_pkg::out_item_t                 out_data
);

	localparam int SW  = ibdz_pkg::SAMPLE_W;
	localparam int CW  = ibdz_pkg::COEF_W;
	localparam int PW  = ibdz_pkg::PROD_W;
	localparam int AW  = ibdz_pkg::ACC_W;
	localparam int HW  = ibdz_pkg::SHIFT_W;
	localparam int FR  = ibdz_pkg::COEF_FRAC;
	localparam int DW  = ibdz_pkg::DZ_W;

	logic signed [CW-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
	logic [DW-1:0]        dz_q;
	logic                 div_ok_q;

	logic signed [SW-1:0] x0_q, x1_q, x2_q, y1_q, y2_q;
	logic signed [SW-1:0] last_q, y_q;

	logic signed [SW-1:0] mul_a;
	logic signed [CW-1:0] mul_b;
	logic signed [PW-1:0] prod_s1;
	logic                 prod_vld_s1, prod_sub_s1;
	logic signed [AW-1:0] acc_q;

	logic signed [AW-1:0] rnd;
	logic signed [AW-1:0] shifted;
	logic signed [HW-1:0] sh_trunc;
	logic [HW-SW:0]       upper;
	logic signed [SW-1:0] y_sat;

	logic signed [SW:0]   diff;
	logic [SW:0]          mag;
	logic                 held;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q     <= CW'(1) << FR;
			b1_q     <= '0;
			b2_q     <= '0;
			a1_q     <= '0;
			a2_q     <= '0;
			dz_q     <= '0;
			div_ok_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				ibdz_pkg::REG_NUM_COEF_0:    b0_q     <= cfg_data[CW-1:0];
				ibdz_pkg::REG_NUM_COEF_1:    b1_q     <= cfg_data[CW-1:0];
				ibdz_pkg::REG_NUM_COEF_2:    b2_q     <= cfg_data[CW-1:0];
				ibdz_pkg::REG_DEN_COEF_1:    a1_q     <= cfg_data[CW-1:0];
				ibdz_pkg::REG_DEN_COEF_2:    a2_q     <= cfg_data[CW-1:0];
				ibdz_pkg::REG_DEAD_ZONE:     dz_q     <= cfg_data[DW-1:0];
				ibdz_pkg::REG_DIVISOR_VALID: div_ok_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// shared multiplier operand select
	always_comb begin
		case (cmd.mul_sel)
			ibdz_pkg::SEL_X0: begin mul_a = x0_q; mul_b = b0_q; end
			ibdz_pkg::SEL_X1: begin mul_a = x1_q; mul_b = b1_q; end
			ibdz_pkg::SEL_X2: begin mul_a = x2_q; mul_b = b2_q; end
			ibdz_pkg::SEL_Y1: begin mul_a = y1_q; mul_b = a1_q; end
			ibdz_pkg::SEL_Y2: begin mul_a = y2_q; mul_b = a2_q; end
			default:          begin mul_a = '0;   mul_b = '0;   end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1     <= mul_a * mul_b;
		prod_sub_s1 <= cmd.mul_sel inside {ibdz_pkg::SEL_Y1, ibdz_pkg::SEL_Y2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= cmd.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (prod_vld_s1) begin
			if (prod_sub_s1) begin
				acc_q <= acc_q - AW'(prod_s1);
			end else begin
				acc_q <= acc_q + AW'(prod_s1);
			end
		end
	end

	// round half up, floor shift, saturate
	always_comb begin
		rnd      = acc_q + (AW'(1) <<< (FR - 1));
		shifted  = rnd >>> FR;
		sh_trunc = shifted[HW-1:0];
		upper    = sh_trunc[HW-1:SW-1];
		if ((upper == '0) || (upper == '1)) begin
			y_sat = sh_trunc[SW-1:0];
		end else if (sh_trunc[HW-1]) begin
			y_sat = {1'b1, {(SW-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(SW-1){1'b1}}};
		end
	end

	// histories and last emitted value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x0_q   <= '0;
			x1_q   <= '0;
			x2_q   <= '0;
			y1_q   <= '0;
			y2_q   <= '0;
			last_q <= '0;
		end else begin
			if (cmd.hist_clear) begin
				x0_q <= '0;
				x1_q <= '0;
				x2_q <= '0;
				y1_q <= '0;
				y2_q <= '0;
			end else if (cmd.hist_shift) begin
				x0_q <= sample_in;
				x1_q <= x0_q;
				x2_q <= x1_q;
			end else if (cmd.round) begin
				y1_q <= div_ok_q ? y_sat : '0;
				y2_q <= y1_q;
			end
			if (cmd.emit && !held) begin
				last_q <= y_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.round) begin
			y_q <= div_ok_q ? y_sat : '0;
		end
	end

	// dead zone compare
	always_comb begin
		diff = {y_q[SW-1], y_q} - {last_q[SW-1], last_q};
		mag  = diff[SW] ? (SW+1)'(-diff) : diff;
		held = mag < {2'b00, dz_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data.filtered_out <= held ? last_q : y_q;
			out_data.held         <= held;
		end
	end

endmodule

[sv/iir_biquad_dead_zone_filter.sv]
// channel  | direction | handshake             | payload
// in       | input     | in_valid / in_stall   | in_data  (req_type, sample_in)
// out      | output    | out_valid / out_stall | out_data (filtered_out, held)
// cfg      | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// from acceptance to result a sample passes through MAC (five products on one shared
// 32x18 multiplier), DRAIN (product register), ROUND (round/saturate), EMIT (dead-zone step)
// the input reopens the cycle after the result is emitted; no new sample is taken before that
// a clear transaction leaves the input open and produces no result
// arst_n clears histories, last emitted value and coefficients to their defaults
// a waiting result does not block the next sample; only a second result waits for it
module iir_biquad_dead_zone_filter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  ibdz_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output ibdz_pkg::out_item_t               out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ibdz_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ibdz_pkg::CFG_DATA_W-1:0]   cfg_data
);

	ibdz_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	ibdz_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_req_type (in_data.req_type),
		.in_stall    (in_stall),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.cmd         (cmd)
	);

	ibdz_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sample_in (in_data.sample_in),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid && out_stall))
		else $error("result written over a waiting result");

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (in_data.req_type == ibdz_pkg::REQ_FILTER)) |=> in_stall)
		else $error("sample accepted but block not busy");

	a_clear_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (in_data.req_type == ibdz_pkg::REQ_CLEAR)) |=> !in_stall)
		else $error("clear transaction held the input side");

	a_emit_then_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("emitted result not presented");
`endif

endmodule

[tb/sv/iir_biquad_dead_zone_filter_tb.sv]
`timescale 1ns / 100ps

module iir_biquad_dead_zone_filter_tb;

	localparam logic [ibdz_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int N_DIR = 34;
	localparam int N_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 225;
	localparam int DRAIN_CYCLES = 20;
	localparam int LONG_HOLD = 400;
	localparam longint SMP_MAX = (longint'(1) <<< (ibdz_pkg::SAMPLE_W - 1)) - 1;
	localparam longint SMP_MIN = -SMP_MAX - 1;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                       kind;
		logic [ibdz_pkg::CFG_IDX_W-1:0]  idx;
		logic [ibdz_pkg::CFG_DATA_W-1:0] data;
		logic                            req;
		logic [ibdz_pkg::SAMPLE_W-1:0]   smp;
		logic                            typed;
		logic [ibdz_pkg::SAMPLE_W-1:0]   want_out;
		logic                            want_held;
	} row_t;

	// typed rows run with b1, b2, a1, a2 at zero and no dead zone, so y follows b0 * x, or zero when div_ok is clear
	localparam row_t DIR_ROWS [N_DIR] = '{
		'{ROW_ITEM, '0, '0, ibdz_pkg::REQ_FILTER, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
		'{ROW_ITEM, '0, '0, ibdz_pkg::REQ_FILTER, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff, 1'b0},
		'{ROW_ITEM, '0, '0, ibdz_pkg::REQ_FILTER, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0},
		'{ROW_ITEM, '0, '0, ibdz_pkg::REQ_FILTER, 32'h0001_0000, 1'b1, 32'h0001_0000, 1'b0},
		'{ROW_ITEM, '0, '0, ibdz_pkg::REQ_CLEAR,  32'hdead_beef, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_ITEM, '0, '0, ibdz_pkg::REQ_FILTER, 32'hffff_ffff, 1'b1, 32'hffff_ffff, 1'b0},
		'{ROW_CFG, ibdz_pkg::REG_DIVISOR_VALID, 31'h0000_0000,
			ibdz_pkg::REQ_FILTER, '0, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, ibdz_pkg::REQ_FILTER, 32'h1234_5678, 1'b1, 32'h0000_0000, 1'b0},
		'{ROW_CFG, ibdz_pkg::REG_DIVISOR_VALID, 31'h7fff_ffff,
			ibdz_pkg::REQ_FILTER, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, REG_UNUSED, 31'h7fff_ffff,
			ibdz_pkg::REQ_FILTER, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, ibdz_pkg::REG_NUM_COEF_0, 31'h0001_ffff,
			ibdz_pkg::REQ_FILTER, '0, 1'b0, '0, 1'b0},
		// saturation at both ends
		'{ROW_ITEM, '0, '0, ibdz_pkg::REQ_FILTER, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff, 1'b0},
		'{ROW_ITEM, '0, '0, ibdz_pkg::REQ_FILTER, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0},
		// upper bits above the coefficient width are dropped, leaving -2.0
		'{ROW_CFG, ibdz_pkg::REG_NUM_COEF_0, 31'h7ffe_0000,
			ibdz_pkg::REQ_FILTER, '0, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, ibdz_pkg::REQ_FILTER, 32'h8000_0000, 1'b1, 32'h7fff_ffff, 1'b0},
		'{ROW_ITEM, '0, '0, ibdz_pkg::REQ_FILTER, 32'h7fff_ffff, 1'b1, 32'h8000_0000, 1'b0},
		'{ROW_CFG, ibdz_pkg::REG_NUM_COEF_0, 31'h0001_0000,
			ibdz_pkg::REQ_FILTER, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, ibdz_pkg::REG_NUM_COEF_1, 31'h0000_8000,
			ibdz_pkg::REQ_FILTER, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, ibdz_pkg::REG_NUM_COEF_2, 31'h0003_c000,
			ibdz_pkg::REQ_FILTER, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, ibdz_pkg::REG_DEN_COEF_1, 31'h0003_0000,
			ibdz_pkg::REQ_FILTER, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, ibdz_pkg::REG_DEN_COEF_2, 31'h0000_8000,
			ibdz_pkg::REQ_FILTER, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, ibdz_pkg::REG_DEAD_ZONE, 31'h0002_0000,
			ibdz_pkg::REQ_FILTER, '0, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, ibdz_pkg::REQ_CLEAR,  32'h0000_0000, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, ibdz_pkg::REQ_FILTER, 32'h0001_0000, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, ibdz_pkg::REQ_FILTER, 32'h0001_0000, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, ibdz_pkg::REQ_FILTER, 32'h0003_0000, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, ibdz_pkg::REQ_FILTER, 32'hfffe_8000, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, ibdz_pkg::REQ_FILTER, 32'h0000_0001, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, ibdz_pkg::REQ_CLEAR,  32'hffff_ffff, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, ibdz_pkg::REQ_FILTER, 32'h0000_0000, 1'b0, '0, 1'b0},
		'{ROW_CFG, ibdz_pkg::REG_DEAD_ZONE, 31'h7fff_ffff,
			ibdz_pkg::REQ_FILTER, '0, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, ibdz_pkg::REQ_FILTER, 32'h7fff_ffff, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, ibdz_pkg::REQ_FILTER, 32'h8000_0000, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, ibdz_pkg::REQ_FILTER, 32'h0000_0000, 1'b0, '0, 1'b0}
	};

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            in_valid  = 1'b0;
	logic                            in_stall;
	ibdz_pkg::in_item_t              in_data   = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	ibdz_pkg::out_item_t             out_data;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [ibdz_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [ibdz_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	// filter settings as the block should hold them
	logic signed [ibdz_pkg::COEF_W-1:0] b0 = 18'sh1_0000;
	logic signed [ibdz_pkg::COEF_W-1:0] b1 = '0;
	logic signed [ibdz_pkg::COEF_W-1:0] b2 = '0;
	logic signed [ibdz_pkg::COEF_W-1:0] a1 = '0;
	logic signed [ibdz_pkg::COEF_W-1:0] a2 = '0;
	logic [ibdz_pkg::DZ_W-1:0]          dz_width = '0;
	logic                               div_ok = 1'b1;

	longint x_hist [3] = '{0, 0, 0};
	longint y_hist [2] = '{0, 0};
	longint last_out = 0;

	ibdz_pkg::out_item_t pending_results [$];
	int err_cnt = 0;
	int burst_left = 0;
	int hold_reqs = 0;

	iir_biquad_dead_zone_filter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic ibdz_pkg::out_item_t biquad_step(
			input logic signed [ibdz_pkg::SAMPLE_W-1:0] smp);
		longint acc;
		longint y;
		longint diff;
		ibdz_pkg::out_item_t res;
		x_hist[2] = x_hist[1];
		x_hist[1] = x_hist[0];
		x_hist[0] = longint'(smp);
		acc = x_hist[0] * longint'(b0) + x_hist[1] * longint'(b1)
			+ x_hist[2] * longint'(b2) - y_hist[0] * longint'(a1)
			- y_hist[1] * longint'(a2);
		if (div_ok) begin
			acc += longint'(1) <<< (ibdz_pkg::COEF_FRAC - 1);
			y = acc >>> ibdz_pkg::COEF_FRAC;
			if (y > SMP_MAX)
				y = SMP_MAX;
			else if (y < SMP_MIN)
				y = SMP_MIN;
		end else begin
			y = 0;
		end
		y_hist[1] = y_hist[0];
		y_hist[0] = y;
		diff = (y >= last_out) ? y - last_out : last_out - y;
		res.held = diff < longint'(dz_width);
		if (!res.held)
			last_out = y;
		res.filtered_out = last_out[ibdz_pkg::SAMPLE_W-1:0];
		return res;
	endfunction

	function automatic void apply_reg(input logic [ibdz_pkg::CFG_IDX_W-1:0] idx,
			input logic [ibdz_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			ibdz_pkg::REG_NUM_COEF_0:    b0 = data[ibdz_pkg::COEF_W-1:0];
			ibdz_pkg::REG_NUM_COEF_1:    b1 = data[ibdz_pkg::COEF_W-1:0];
			ibdz_pkg::REG_NUM_COEF_2:    b2 = data[ibdz_pkg::COEF_W-1:0];
			ibdz_pkg::REG_DEN_COEF_1:    a1 = data[ibdz_pkg::COEF_W-1:0];
			ibdz_pkg::REG_DEN_COEF_2:    a2 = data[ibdz_pkg::COEF_W-1:0];
			ibdz_pkg::REG_DEAD_ZONE:     dz_width = data[ibdz_pkg::DZ_W-1:0];
			ibdz_pkg::REG_DIVISOR_VALID: div_ok = data[0];
			default: ;
		endcase
	endfunction

	function automatic logic [ibdz_pkg::CFG_DATA_W-1:0] rand_word();
		return ibdz_pkg::CFG_DATA_W'($urandom);
	endfunction

	// coefficient in the low bits, random junk above it
	function automatic logic [ibdz_pkg::CFG_DATA_W-1:0] coef_word(input int val);
		logic [ibdz_pkg::CFG_DATA_W-1:0] d;
		d = rand_word();
		d[ibdz_pkg::COEF_W-1:0] = val[ibdz_pkg::COEF_W-1:0];
		return d;
	endfunction

	function automatic int small_val(input int mag);
		return int'($urandom_range(0, 2 * mag)) - mag;
	endfunction

	function automatic ibdz_pkg::in_item_t rand_item(input int kind);
		ibdz_pkg::in_item_t it;
		int pick;
		it.req_type = ($urandom_range(0, 15) == 0) ? ibdz_pkg::REQ_CLEAR : ibdz_pkg::REQ_FILTER;
		pick = $urandom_range(0, 9);
		if (pick < ((kind == 1 || kind == 3) ? 7 : 2))
			it.sample_in = small_val(1 << 18);
		else if (pick < 9)
			it.sample_in = $urandom;
		else begin
			case ($urandom_range(0, 4))
				0: it.sample_in = 32'h7fff_ffff;
				1: it.sample_in = 32'h8000_0000;
				2: it.sample_in = 32'h0000_0000;
				3: it.sample_in = 32'hffff_ffff;
				default: it.sample_in = 32'h0000_0001;
			endcase
		end
		return it;
	endfunction

	task automatic send_item(input ibdz_pkg::in_item_t it, input logic typed,
			input ibdz_pkg::out_item_t want);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 40);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		burst_left--;
		if (it.req_type == ibdz_pkg::REQ_CLEAR) begin
			x_hist = '{0, 0, 0};
			y_hist = '{0, 0};
		end else begin
			if (typed)
				void'(biquad_step(it.sample_in));
			pending_results.push_back(typed ? want : biquad_step(it.sample_in));
		end
	endtask

	// also covers a trailing clear transaction still in flight
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ibdz_pkg::CFG_IDX_W-1:0] idx,
			input logic [ibdz_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic program_phase(input int p);
		logic [ibdz_pkg::CFG_DATA_W-1:0] div_word;
		div_word = rand_word();
		case (p % 4)
			0: begin
				write_reg(ibdz_pkg::REG_NUM_COEF_0, rand_word());
				write_reg(ibdz_pkg::REG_NUM_COEF_1, rand_word());
				write_reg(ibdz_pkg::REG_NUM_COEF_2, rand_word());
				write_reg(ibdz_pkg::REG_DEN_COEF_1, rand_word());
				write_reg(ibdz_pkg::REG_DEN_COEF_2, rand_word());
				write_reg(ibdz_pkg::REG_DEAD_ZONE, rand_word());
				div_word[0] = 1'b1;
			end
			2: begin
				// all at the positive ends, or all at the negative ends
				for (int r = 0; r < 5; r++)
					write_reg(ibdz_pkg::REG_NUM_COEF_0 + r[ibdz_pkg::CFG_IDX_W-1:0],
						coef_word((p == 2) ? 131071 : -131072));
				write_reg(ibdz_pkg::REG_DEAD_ZONE, (p == 2) ? 31'h7fff_ffff : 31'h0);
				div_word[0] = 1'b1;
			end
			default: begin
				// stable section so the dead zone sees small steps
				write_reg(ibdz_pkg::REG_NUM_COEF_0, coef_word(small_val(65536)));
				write_reg(ibdz_pkg::REG_NUM_COEF_1, coef_word(small_val(32768)));
				write_reg(ibdz_pkg::REG_NUM_COEF_2, coef_word(small_val(32768)));
				write_reg(ibdz_pkg::REG_DEN_COEF_1, coef_word(small_val(32768)));
				write_reg(ibdz_pkg::REG_DEN_COEF_2, coef_word(small_val(26000)));
				write_reg(ibdz_pkg::REG_DEAD_ZONE,
					ibdz_pkg::CFG_DATA_W'($urandom_range(0, 1 << 20)));
				div_word[0] = (p % 4 == 1);
			end
		endcase
		write_reg(ibdz_pkg::REG_DIVISOR_VALID, div_word);
		write_reg(REG_UNUSED, rand_word());
	endtask

	// receiver stall pattern, with an occasional long hold-off
	always @(negedge clk) begin
		static int hold_seen = 0;
		static int hold_left = 0;
		static int mode = 0;
		static int mode_left = 0;
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(5, 200);
			end
			mode_left--;
			case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		ibdz_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction: filtered_out %h held %b",
					out_data.filtered_out, out_data.held);
				err_cnt++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.filtered_out !== want.filtered_out) begin
					$error("filtered_out expected %h got %h",
						want.filtered_out, out_data.filtered_out);
					err_cnt++;
				end
				if (out_data.held !== want.held) begin
					$error("held expected %b got %b", want.held, out_data.held);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		ibdz_pkg::in_item_t it;
		ibdz_pkg::out_item_t want;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < N_DIR; r++) begin
			if (DIR_ROWS[r].kind == ROW_CFG) begin
				wait_idle();
				write_reg(DIR_ROWS[r].idx, DIR_ROWS[r].data);
			end else begin
				it.req_type = DIR_ROWS[r].req;
				it.sample_in = DIR_ROWS[r].smp;
				want.filtered_out = DIR_ROWS[r].want_out;
				want.held = DIR_ROWS[r].want_held;
				send_item(it, DIR_ROWS[r].typed, want);
			end
		end

		for (int p = 0; p < N_PHASES; p++) begin
			wait_idle();
			program_phase(p);
			if (p == 1 || p == 5)
				hold_reqs++;
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_item(rand_item(p % 4), 1'b0, '0);
		end

		wait_idle();
		if (err_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
